// ----- design/cltok_pkg.sv -----
// shared types, constants and character classes of the token scanner
package cltok_pkg;

  // longest token length that is counted; the length port is 8 bits wide
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [7:0] LEN_CAP = LEN_CAP_INT[7:0];

  // result queue depth, must be a power of two and at least two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LPAR  = 8'h28;

  typedef enum logic [3:0] {
    K_IDENT  = 4'd0,
    K_INT    = 4'd1,
    K_DEC    = 4'd2,
    K_HEX    = 4'd3,
    K_PLUS   = 4'd4,
    K_INCR   = 4'd5,
    K_MINUS  = 4'd6,
    K_DECR   = 4'd7,
    K_ARROW  = 4'd8,
    K_SEMI   = 4'd9,
    K_LPAREN = 4'd10,
    K_ERROR  = 4'd11,
    K_END    = 4'd12
  } token_kind_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_IDENT = 4'd1,
    S_INT   = 4'd2,
    S_DEC   = 4'd3,
    S_ZERO  = 4'd4,
    S_HEX   = 4'd5,
    S_PLUS  = 4'd6,
    S_MINUS = 4'd7,
    S_ERR   = 4'd8
  } scan_state_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  len;
    logic [15:0] line;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

endpackage

// ----- design/c_like_token_scanner.sv -----
// character scanner for a small c-like token set with a result queue
// One source character enters per cycle on the in_valid/in_ready channel while
// in_ready is high. The scanner state, the running token length and the line count
// are updated in the cycle the character is accepted; the zero, one or two results
// it causes (a finished token and a ';' or '(' token that starts right after it, or
// a flushed token and the end token) go into a 4-entry result queue that drains
// one item per cycle on out_valid/out_ready while out_ready is high. The input is
// taken whenever at least two queue slots are free, so with the output side always
// ready it takes one character per cycle unless a second character with two results
// comes before any character with no result. Lengths saturate at 255, line numbers
// wrap at 16 bits. Reset clears state and queue at once; no warm-up period.
module c_like_token_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [7:0]  token_length,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  // scanner state
  cltok_pkg::scan_state_t scan_state, scan_state_next;
  logic [7:0]  token_len, token_len_next;
  logic [15:0] line_count, line_count_next;

  // result queue
  cltok_pkg::result_t queue [cltok_pkg::QUEUE_DEPTH];
  logic [cltok_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [cltok_pkg::QCNT_W-1:0] count, count_next;

  logic in_acc, out_acc;

  // decode of the character as the first of a new token
  cltok_pkg::scan_state_t b_state;
  logic [7:0]             b_len;
  logic                   b_emit;
  cltok_pkg::token_kind_t b_kind;
  logic                   b_nl;

  // up to two results of this character, in order
  logic                   f_v, s_v;
  cltok_pkg::token_kind_t f_k, s_k, fin_kind;
  logic [7:0]             f_l, s_l;
  logic                   fin, start, nl;
  logic [7:0]             grown;
  logic [1:0]             push_n;
  cltok_pkg::result_t     slot0, slot1;

  assign in_ready  = (count <= cltok_pkg::QCNT_W'(cltok_pkg::QUEUE_DEPTH - 2));
  assign in_acc    = in_valid & in_ready;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid & out_ready;

  // saturating length increment
  assign grown = (token_len < cltok_pkg::LEN_CAP) ? token_len + 8'd1 : token_len;

  always_comb begin
    b_state = cltok_pkg::S_IDLE;
    b_len   = 8'd0;
    b_emit  = 1'b0;
    b_kind  = cltok_pkg::K_SEMI;
    b_nl    = 1'b0;
    if (cltok_pkg::is_space(char_code)) begin
      b_nl = (char_code == cltok_pkg::CH_NL);
    end else begin
      b_len = 8'd1;
      priority if (cltok_pkg::is_alpha(char_code)) begin
        b_state = cltok_pkg::S_IDENT;
      end else if (char_code == cltok_pkg::CH_ZERO) begin
        b_state = cltok_pkg::S_ZERO;
      end else if (cltok_pkg::is_digit(char_code)) begin
        b_state = cltok_pkg::S_INT;
      end else if (char_code == cltok_pkg::CH_PLUS) begin
        b_state = cltok_pkg::S_PLUS;
      end else if (char_code == cltok_pkg::CH_MINUS) begin
        b_state = cltok_pkg::S_MINUS;
      end else if (char_code == cltok_pkg::CH_SEMI) begin
        // single-character token goes out at once
        b_emit = 1'b1;
        b_kind = cltok_pkg::K_SEMI;
        b_len  = 8'd0;
      end else if (char_code == cltok_pkg::CH_LPAR) begin
        b_emit = 1'b1;
        b_kind = cltok_pkg::K_LPAREN;
        b_len  = 8'd0;
      end else begin
        b_state = cltok_pkg::S_ERR;
      end
    end
  end

  always_comb begin
    f_v             = 1'b0;
    f_k             = cltok_pkg::K_END;
    f_l             = 8'd0;
    s_v             = 1'b0;
    s_k             = cltok_pkg::K_END;
    s_l             = 8'd0;
    fin             = 1'b0;
    fin_kind        = cltok_pkg::K_ERROR;
    start           = 1'b0;
    nl              = 1'b0;
    scan_state_next = scan_state;
    token_len_next  = token_len;

    if (end_of_input) begin
      // flush any pending token, then the end token
      f_l = token_len;
      unique case (scan_state)
        cltok_pkg::S_IDENT: begin f_v = 1'b1; f_k = cltok_pkg::K_IDENT; end
        cltok_pkg::S_INT:   begin f_v = 1'b1; f_k = cltok_pkg::K_INT;   end
        cltok_pkg::S_DEC:   begin f_v = 1'b1; f_k = cltok_pkg::K_DEC;   end
        cltok_pkg::S_ZERO:  begin f_v = 1'b1; f_k = cltok_pkg::K_INT;   end
        cltok_pkg::S_HEX:   begin f_v = 1'b1; f_k = cltok_pkg::K_HEX;   end
        cltok_pkg::S_PLUS:  begin f_v = 1'b1; f_k = cltok_pkg::K_PLUS;  end
        cltok_pkg::S_MINUS: begin f_v = 1'b1; f_k = cltok_pkg::K_MINUS; end
        cltok_pkg::S_ERR:   begin f_v = 1'b1; f_k = cltok_pkg::K_ERROR; end
        default:            f_v = 1'b0;
      endcase
      s_v             = 1'b1;
      s_k             = cltok_pkg::K_END;
      s_l             = 8'd0;
      scan_state_next = cltok_pkg::S_IDLE;
      token_len_next  = 8'd0;
    end else begin
      unique case (scan_state)
        cltok_pkg::S_IDENT: begin
          if (cltok_pkg::is_word(char_code)) token_len_next = grown;
          else begin fin = 1'b1; fin_kind = cltok_pkg::K_IDENT; end
        end
        cltok_pkg::S_INT: begin
          priority if (cltok_pkg::is_digit(char_code)) begin
            token_len_next = grown;
          end else if (char_code == cltok_pkg::CH_DOT) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_DEC;
          end else if (cltok_pkg::is_word(char_code)) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_ERR;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_INT;
          end
        end
        cltok_pkg::S_DEC: begin
          // a second dot ends the decimal and starts an error token
          priority if (cltok_pkg::is_digit(char_code)) begin
            token_len_next = grown;
          end else if (cltok_pkg::is_word(char_code)) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_ERR;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_DEC;
          end
        end
        cltok_pkg::S_ZERO: begin
          priority if (char_code == cltok_pkg::CH_LC_X || char_code == cltok_pkg::CH_UC_X)
          begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_HEX;
          end else if (cltok_pkg::is_digit(char_code)) begin
            // leading zero dropped, count restarts at this digit
            token_len_next  = 8'd1;
            scan_state_next = cltok_pkg::S_INT;
          end else if (char_code == cltok_pkg::CH_DOT) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_DEC;
          end else if (cltok_pkg::is_word(char_code)) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_ERR;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_INT;
          end
        end
        cltok_pkg::S_HEX: begin
          priority if (cltok_pkg::is_hex(char_code)) begin
            token_len_next = grown;
          end else if (cltok_pkg::is_word(char_code)) begin
            token_len_next  = grown;
            scan_state_next = cltok_pkg::S_ERR;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_HEX;
          end
        end
        cltok_pkg::S_PLUS: begin
          if (char_code == cltok_pkg::CH_PLUS) begin
            f_v             = 1'b1;
            f_k             = cltok_pkg::K_INCR;
            f_l             = grown;
            scan_state_next = cltok_pkg::S_IDLE;
            token_len_next  = 8'd0;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_PLUS;
          end
        end
        cltok_pkg::S_MINUS: begin
          if (char_code == cltok_pkg::CH_MINUS || char_code == cltok_pkg::CH_GT) begin
            f_v             = 1'b1;
            f_k             = (char_code == cltok_pkg::CH_MINUS) ? cltok_pkg::K_DECR
                                                                 : cltok_pkg::K_ARROW;
            f_l             = grown;
            scan_state_next = cltok_pkg::S_IDLE;
            token_len_next  = 8'd0;
          end else begin
            fin = 1'b1; fin_kind = cltok_pkg::K_MINUS;
          end
        end
        cltok_pkg::S_ERR: begin
          if (!cltok_pkg::is_space(char_code)) token_len_next = grown;
          else begin fin = 1'b1; fin_kind = cltok_pkg::K_ERROR; end
        end
        default: start = 1'b1;
      endcase

      // a finished token is emitted, then the character starts the next one
      if (fin) begin
        f_v   = 1'b1;
        f_k   = fin_kind;
        f_l   = token_len;
        start = 1'b1;
      end
      if (start) begin
        scan_state_next = b_state;
        token_len_next  = b_len;
        nl              = b_nl;
        s_v             = b_emit;
        s_k             = b_kind;
        s_l             = 8'd1;
      end
    end
  end

  // pack the results into consecutive queue slots; the last one carries last_of_run
  assign push_n = {1'b0, f_v} + {1'b0, s_v};
  assign line_count_next = line_count + {15'd0, nl};

  always_comb begin
    slot0.kind = f_v ? f_k : s_k;
    slot0.len  = f_v ? f_l : s_l;
    slot0.line = line_count;
    slot0.last = (push_n == 2'd1);
    slot1.kind = s_k;
    slot1.len  = s_l;
    slot1.line = line_count;
    slot1.last = 1'b1;
  end

  assign count_next = count
                    + (in_acc ? cltok_pkg::QCNT_W'(push_n) : '0)
                    - cltok_pkg::QCNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= cltok_pkg::S_IDLE;
      token_len  <= 8'd0;
      line_count <= 16'd0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (in_acc) begin
        scan_state <= scan_state_next;
        token_len  <= token_len_next;
        line_count <= line_count_next;
        wr_ptr     <= wr_ptr + cltok_pkg::QPTR_W'(push_n);
      end
      if (out_acc) rd_ptr <= rd_ptr + cltok_pkg::QPTR_W'(1);
      count <= count_next;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && push_n != 2'd0) queue[wr_ptr] <= slot0;
    if (in_acc && push_n == 2'd2) queue[wr_ptr + cltok_pkg::QPTR_W'(1)] <= slot1;
  end

  assign token_kind   = queue[rd_ptr].kind;
  assign token_length = queue[rd_ptr].len;
  assign line_number  = queue[rd_ptr].line;
  assign last_of_run  = queue[rd_ptr].last;

endmodule
